// File: design/dersig_pkg.sv
// ----------------------------------------------------------------------------
// dersig_pkg: shared types and constants for the DER signature unpacker
// Request and result payloads, the parser phase type, the status bundle
// passed from the parser to the result buffer, and the DER tag values.
// ----------------------------------------------------------------------------
package dersig_pkg;

  // DER tag values and fixed byte codes
  localparam logic [7:0] SEQ_TAG    = 8'h30;
  localparam logic [7:0] INT_TAG    = 8'h02;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] ROOM_RESET = 8'd64;

  // Width of one result word and its index
  localparam int WORD_BITS  = 64;
  localparam int INDEX_BITS = 3;
  localparam int MAX_WORDS  = 8;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SEQ_TAG  = 3'd0,
    PH_SEQ_LEN  = 3'd1,
    PH_INT_TAG  = 3'd2,
    PH_INT_LEN  = 3'd3,
    PH_INT_DATA = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  // One request: a byte of the DER stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_req_t;

  // One result: a word of R||S
  typedef struct packed {
    logic [WORD_BITS-1:0]  raw_word;
    logic [INDEX_BITS-1:0] word_index;
    logic                  ok;
    logic                  end_of_run;
  } out_res_t;

  // Parser status at the close of a message
  typedef struct packed {
    logic done;
    logic good;
  } msg_stat_t;

endpackage

// File: design/dersig_parse.sv
// ----------------------------------------------------------------------------
// dersig_parse: byte-wise DER parser and R/S byte store
// Checks the SEQUENCE and INTEGER framing one byte per cycle with take high,
// strips one leading zero per integer, right-aligns each integer into its
// store half and, on the final byte, reports pass/fail and exposes the store.
// ----------------------------------------------------------------------------
module dersig_parse
  import dersig_pkg::*;
#(
  parameter int  COMPONENT_BYTES   = 32,
  parameter int  MIN_MESSAGE_BYTES = 68,
  localparam int STORE_BYTES       = 2 * COMPONENT_BYTES,
  localparam int OUT_BYTES         = (STORE_BYTES < MAX_WORDS * 8) ? STORE_BYTES
                                                                   : MAX_WORDS * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  in_req_t                req,
  input  logic [7:0]             room,
  output msg_stat_t              stat,
  output logic [OUT_BYTES*8-1:0] snap
);

  localparam int SLOT_W = $clog2(STORE_BYTES + 1);
  localparam int LEFT_W = $clog2(COMPONENT_BYTES + 2);

  phase_t              phase_r, phase_nxt;
  logic [7:0]          seen_r, seen_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic                first_r, first_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                failed_r, failed_nxt;
  logic                second_r, second_nxt;
  logic [OUT_BYTES-1:0] vld_r, vld_nxt;
  logic [7:0]          store_r [OUT_BYTES];

  logic [7:0]          b;
  logic [SLOT_W-1:0]   base;
  logic [SLOT_W-1:0]   slot_lead;
  logic [SLOT_W-1:0]   slot_zero;
  logic [SLOT_W-1:0]   slot_eff;
  logic [LEFT_W-1:0]   left_dec;
  logic                we;
  logic                good;

  assign b         = req.data_byte;
  assign base      = second_r ? SLOT_W'(COMPONENT_BYTES) : '0;
  assign left_dec  = left_r - LEFT_W'(1);
  assign slot_lead = base + SLOT_W'(COMPONENT_BYTES) - SLOT_W'(left_r);
  assign slot_zero = base + SLOT_W'(COMPONENT_BYTES) - SLOT_W'(left_dec);
  assign slot_eff  = first_r ? slot_lead : slot_r;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEQ_TAG;
      seen_r   <= '0;
      left_r   <= '0;
      first_r  <= 1'b0;
      slot_r   <= '0;
      failed_r <= 1'b0;
      second_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      seen_r   <= seen_nxt;
      left_r   <= left_nxt;
      first_r  <= first_nxt;
      slot_r   <= slot_nxt;
      failed_r <= failed_nxt;
      second_r <= second_nxt;
      vld_r    <= vld_nxt;
    end
  end

  // Advance the parser by one byte
  always_comb begin
    phase_nxt  = phase_r;
    seen_nxt   = seen_r;
    left_nxt   = left_r;
    first_nxt  = first_r;
    slot_nxt   = slot_r;
    failed_nxt = failed_r;
    second_nxt = second_r;
    we         = 1'b0;
    good       = 1'b0;
    if (take) begin
      seen_nxt = (seen_r == 8'hFF) ? seen_r : seen_r + 8'd1;
      if (!failed_r) begin
        unique case (phase_r)
          PH_SEQ_TAG: begin
            if (b != SEQ_TAG) failed_nxt = 1'b1;
            phase_nxt = PH_SEQ_LEN;
          end
          PH_SEQ_LEN: begin
            phase_nxt = PH_INT_TAG;
          end
          PH_INT_TAG: begin
            if (b != INT_TAG) failed_nxt = 1'b1;
            phase_nxt = PH_INT_LEN;
          end
          PH_INT_LEN: begin
            if (b == ZERO_BYTE || b > 8'(COMPONENT_BYTES + 1)) begin
              failed_nxt = 1'b1;
            end else begin
              left_nxt  = LEFT_W'(b);
              first_nxt = 1'b1;
              phase_nxt = PH_INT_DATA;
            end
          end
          PH_INT_DATA: begin
            first_nxt = 1'b0;
            if (first_r && b == ZERO_BYTE) begin
              // strip the leading zero; nothing left means failure
              if (left_dec == '0) begin
                failed_nxt = 1'b1;
              end else begin
                slot_nxt = slot_zero;
                left_nxt = left_dec;
              end
            end else if (first_r && left_r > LEFT_W'(COMPONENT_BYTES)) begin
              failed_nxt = 1'b1;
            end else begin
              we       = 1'b1;
              slot_nxt = slot_eff + SLOT_W'(1);
              left_nxt = left_dec;
              if (left_dec == '0) begin
                if (second_r) begin
                  phase_nxt = PH_DONE;
                end else begin
                  second_nxt = 1'b1;
                  phase_nxt  = PH_INT_TAG;
                end
              end
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
      good = !failed_nxt && phase_nxt == PH_DONE &&
             seen_nxt >= 8'(MIN_MESSAGE_BYTES) && room >= 8'(STORE_BYTES);
      // Drop all message state after the final byte
      if (req.is_final) begin
        phase_nxt  = PH_SEQ_TAG;
        seen_nxt   = '0;
        left_nxt   = '0;
        first_nxt  = 1'b0;
        slot_nxt   = '0;
        failed_nxt = 1'b0;
        second_nxt = 1'b0;
      end
    end
  end

  // Mark written bytes; clear all marks at message end
  always_comb begin
    for (int i = 0; i < OUT_BYTES; i++) begin
      if (take && req.is_final) begin
        vld_nxt[i] = 1'b0;
      end else begin
        vld_nxt[i] = vld_r[i] | (we && slot_eff == SLOT_W'(i));
      end
    end
  end

  // Store the data byte
  always_ff @(posedge clk) begin
    for (int i = 0; i < OUT_BYTES; i++) begin
      if (we && slot_eff == SLOT_W'(i)) store_r[i] <= b;
    end
  end

  // Expose the store including this cycle's byte; unwritten bytes read zero
  always_comb begin
    for (int i = 0; i < OUT_BYTES; i++) begin
      if (we && slot_eff == SLOT_W'(i)) begin
        snap[8*i +: 8] = b;
      end else begin
        snap[8*i +: 8] = vld_r[i] ? store_r[i] : ZERO_BYTE;
      end
    end
  end

  assign stat.done = take && req.is_final;
  assign stat.good = good;

endmodule

// File: design/der_ecdsa_signature_to_raw.sv
// ----------------------------------------------------------------------------
// der_ecdsa_signature_to_raw: DER ECDSA signature to raw R||S words
// Parses a DER signature one byte per request and, on the final byte,
// delivers the raw signature as big-endian 64-bit words or one failure word.
// ----------------------------------------------------------------------------
// Throughput: one byte request per cycle; a final byte waits only while the
//   previous message still has results beyond the one leaving this cycle.
// Output: the first result shows in the cycle after the final byte is taken;
//   the words then leave one per cycle unless stalled (up to eight, or one on failure).
// Reset: synchronous, active low; clears parser state, byte marks and the output
//   buffer busy flag and sets room_r to 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
module der_ecdsa_signature_to_raw
  import dersig_pkg::*;
#(
  parameter int COMPONENT_BYTES   = 32,
  parameter int MIN_MESSAGE_BYTES = 68
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_req_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_res_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int STORE_BYTES = 2 * COMPONENT_BYTES;
  localparam int OUT_BYTES   = (STORE_BYTES < MAX_WORDS * 8) ? STORE_BYTES : MAX_WORDS * 8;
  localparam int OUT_WORDS   = (OUT_BYTES + 7) / 8;
  localparam int BUF_BITS    = OUT_WORDS * WORD_BITS;

  logic [7:0]             room_r;
  logic                   busy_r;
  logic                   ok_r;
  logic [INDEX_BITS-1:0]  idx_r;
  logic [INDEX_BITS-1:0]  last_idx_r;
  logic [BUF_BITS-1:0]    buf_r;
  logic [BUF_BITS-1:0]    buf_load;

  logic                   take;
  logic                   out_take;
  logic                   last_go;
  logic                   buf_free;
  msg_stat_t              stat;
  logic [OUT_BYTES*8-1:0] snap;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_r <= ROOM_RESET;
    end else if (cfg_wr_en) begin
      room_r <= cfg_wr_data;
    end
  end

  // Request handshake: only a final byte waits for the result buffer
  assign out_take = busy_r && !out_stall;
  assign last_go  = out_take && idx_r == last_idx_r;
  assign buf_free = !busy_r || last_go;
  assign in_stall = in_valid && in_data.is_final && !buf_free;
  assign take     = in_valid && !in_stall;

  dersig_parse #(
    .COMPONENT_BYTES  (COMPONENT_BYTES),
    .MIN_MESSAGE_BYTES(MIN_MESSAGE_BYTES)
  ) u_parse (
    .clk  (clk),
    .rst_n(rst_n),
    .take (take),
    .req  (in_data),
    .room (room_r),
    .stat (stat),
    .snap (snap)
  );

  // Lay out the store with byte zero at the top; pad low bytes with zero
  always_comb begin
    buf_load = '0;
    for (int i = 0; i < OUT_BYTES; i++) begin
      buf_load[BUF_BITS-1-8*i -: 8] = stat.good ? snap[8*i +: 8] : ZERO_BYTE;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (stat.done) begin
      busy_r <= 1'b1;
    end else if (last_go) begin
      busy_r <= 1'b0;
    end
  end

  // Load a finished message, shift one word out per result taken
  always_ff @(posedge clk) begin
    if (stat.done) begin
      buf_r      <= buf_load;
      ok_r       <= stat.good;
      idx_r      <= '0;
      last_idx_r <= stat.good ? INDEX_BITS'(OUT_WORDS - 1) : '0;
    end else if (out_take) begin
      buf_r <= buf_r << WORD_BITS;
      idx_r <= idx_r + INDEX_BITS'(1);
    end
  end

  assign out_valid           = busy_r;
  assign out_data.raw_word   = buf_r[BUF_BITS-1 -: WORD_BITS];
  assign out_data.word_index = idx_r;
  assign out_data.ok         = ok_r;
  assign out_data.end_of_run = idx_r == last_idx_r;

  // A taken final byte always yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.is_final |=> out_valid)
    else $error("final byte did not produce a result");

  // A failure is one zero word that closes the run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |->
      out_data.end_of_run && out_data.raw_word == '0 && out_data.word_index == '0)
    else $error("malformed failure result");

  // Word index never passes the last word of the run
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_idx_r)
    else $error("word index overran the run");

  // Taking the last word without a new load empties the buffer
  assert property (@(posedge clk) disable iff (!rst_n)
    last_go && !stat.done |=> !out_valid)
    else $error("result repeated after end of run");

endmodule
